>>> sv/window_stack_hit_drag_unit_assert.svh
// assertion macros for the window stack unit
// no dependencies; take it in with an include inside the module that asserts
`ifndef WINDOW_STACK_HIT_DRAG_UNIT_ASSERT_SVH
`define WINDOW_STACK_HIT_DRAG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// a condition that must hold at every clock edge out of reset
`define WSHD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wshd check failed");
// a condition that must hold in the cycle after a trigger
`define WSHD_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("wshd check failed");
`else
`define WSHD_ASSERT_ALWAYS(lbl, cond)
`define WSHD_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

>>> sv/wshd_pkg.sv
// shared constants and types of the window stack unit
// no dependencies; used by the interfaces and the window stack module
package wshd_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int COORD_BITS      = 12;
    localparam int OUT_SLOT_BITS   = 4;
    localparam int CASC_BITS       = 8;
    localparam int CFG_IDX_BITS    = 1;

    // cascade placement
    localparam int CASCADE_START = 80;
    localparam int CASCADE_STEP  = 40;
    localparam int CASCADE_LIMIT = 200;

    // title bar depth and the corner that spawns a window
    localparam int GRAB_ROWS   = 20;
    localparam int CORNER_SIZE = 100;
    localparam int CORNER_W    = 200;
    localparam int CORNER_H    = 150;

    // register reset values and indexes
    localparam int SCREEN_W_RST = 1024;
    localparam int SCREEN_H_RST = 768;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } rect_t;

endpackage

>>> sv/wshd_if.sv
// item channels of the window stack unit: command in, result out
// depends on wshd_pkg
interface wshd_cmd_if;
    import wshd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] mouse_x;
    logic [COORD_BITS-1:0] mouse_y;
    logic                  pressed;
    logic [COORD_BITS-1:0] new_width;
    logic [COORD_BITS-1:0] new_height;
    modport source (output valid, mode, mouse_x, mouse_y, pressed, new_width, new_height,
                    input ready);
    modport sink (input valid, mode, mouse_x, mouse_y, pressed, new_width, new_height,
                  output ready);
endinterface

interface wshd_res_if;
    import wshd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     active_valid;
    logic [OUT_SLOT_BITS-1:0] active_slot;
    logic                     dragging;
    logic                     window_touched;
    logic [OUT_SLOT_BITS-1:0] window_slot;
    logic [COORD_BITS-1:0]    window_x;
    logic [COORD_BITS-1:0]    window_y;
    logic                     created;
    logic                     rejected;
    modport source (output valid, active_valid, active_slot, dragging, window_touched,
                    window_slot, window_x, window_y, created, rejected, input ready);
    modport sink (input valid, active_valid, active_slot, dragging, window_touched,
                  window_slot, window_x, window_y, created, rejected, output ready);
endinterface

>>> sv/window_stack_hit_drag_unit.sv
// Window stack with hit test, raise on click, title bar drag and cascading creation.
// One item at a time, with N the number of windows. A create is rejected when the table
// is full. A press that hits a window raises it to stack position 0, on top, and starts a
// drag when it hits the title bar. A press on empty space scans all N windows, and a
// corner press then creates a window. The stack-order memory is read once per step of
// the scan and of the raise. A new item is accepted while the previous result still
// waits in the output register; the next result waits in its last step until that
// register frees.
`include "window_stack_hit_drag_unit_assert.svh"
module window_stack_hit_drag_unit #(
    parameter int MAX_WINDOWS = wshd_pkg::MAX_WINDOWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wshd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [wshd_pkg::COORD_BITS-1:0]   cfg_data,
    wshd_cmd_if.sink                          cmd,
    wshd_res_if.source                        res
);
    import wshd_pkg::*;

    localparam int SLOT_BITS = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_WINDOWS + 1);
    localparam int CW        = COORD_BITS;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_ORD_RD  = 10'b0000000010,
        S_RECT_RD = 10'b0000000100,
        S_TEST    = 10'b0000001000,
        S_CREATE  = 10'b0000010000,
        S_SH_RD   = 10'b0000100000,
        S_SH_WR   = 10'b0001000000,
        S_POST    = 10'b0010000000,
        S_DRAG_WR = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CW-1:0] scr_w_reg, scr_w_next, scr_h_reg, scr_h_next;

    // current item
    logic          mode_reg, mode_next, pr_reg, pr_next;
    logic [CW-1:0] mx_reg, mx_next, my_reg, my_next, nw_reg, nw_next, nh_reg, nh_next;

    // scan and shift control
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next, head_reg, head_next;

    // block state
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 act_on_reg, act_on_next, drag_on_reg, drag_on_next;
    logic [SLOT_BITS-1:0] act_idx_reg, act_idx_next, drag_idx_reg, drag_idx_next;
    logic [CW-1:0]        gdx_reg, gdx_next, gdy_reg, gdy_next;
    logic                 prev_pr_reg, prev_pr_next;
    logic [CASC_BITS-1:0] casc_reg, casc_next;

    // result being built
    logic                 touched_reg, touched_next, created_reg, created_next;
    logic                 rejected_reg, rejected_next;
    logic [SLOT_BITS-1:0] tslot_reg, tslot_next;
    logic [CW-1:0]        tx_reg, tx_next, ty_reg, ty_next;

    // output register
    logic                     ov_reg, ov_next;
    logic                     o_act_v_reg, o_act_v_next, o_drag_reg, o_drag_next;
    logic                     o_touch_reg, o_touch_next, o_cre_reg, o_cre_next;
    logic                     o_rej_reg, o_rej_next;
    logic [OUT_SLOT_BITS-1:0] o_act_s_reg, o_act_s_next, o_win_s_reg, o_win_s_next;
    logic [CW-1:0]            o_x_reg, o_x_next, o_y_reg, o_y_next;

    // memories
    logic                 ord_we;
    logic [SLOT_BITS-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic                 rect_we;
    logic [SLOT_BITS-1:0] rect_waddr, rect_raddr;
    rect_t                rect_wdata, rect_rdata;

    wshd_ram #(.WIDTH(SLOT_BITS), .DEPTH(MAX_WINDOWS)) u_order_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    wshd_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_WINDOWS)) u_rect_ram (
        .clk(clk), .we(rect_we), .waddr(rect_waddr), .wdata(rect_wdata),
        .raddr(rect_raddr), .rdata(rect_rdata)
    );

    // geometry tests on the rectangle just read
    logic              hit, grab, corner, full;
    logic [CW:0]       right_edge, bottom_edge, grab_edge;
    logic [CNT_BITS-1:0]  idx_dec;
    logic [CASC_BITS:0]   casc_sum;
    logic signed [CW+1:0] px, py, hx, hy, cx, cy;
    logic [CW-1:0]        nx, ny, cw_sat, ch_sat;

    always_comb
    begin
        right_edge  = {1'b0, rect_rdata.left} + {1'b0, rect_rdata.width};
        bottom_edge = {1'b0, rect_rdata.top} + {1'b0, rect_rdata.height};
        grab_edge   = {1'b0, rect_rdata.top} + (CW+1)'(GRAB_ROWS);
        hit  = (mx_reg >= rect_rdata.left) && ({1'b0, mx_reg} <= right_edge) &&
               (my_reg >= rect_rdata.top) && ({1'b0, my_reg} <= bottom_edge);
        grab = (my_reg >= rect_rdata.top) && ({1'b0, my_reg} <= grab_edge);
        corner = ($signed({2'b00, mx_reg}) >
                  $signed({2'b00, scr_w_reg}) - $signed((CW+2)'(CORNER_SIZE))) &&
                 ($signed({2'b00, my_reg}) >
                  $signed({2'b00, scr_h_reg}) - $signed((CW+2)'(CORNER_SIZE)));
        full    = (count_reg == CNT_BITS'(MAX_WINDOWS));
        idx_dec = idx_reg - CNT_BITS'(1);
        casc_sum = {1'b0, casc_reg} + (CASC_BITS+1)'(CASCADE_STEP);
        cw_sat  = (nw_reg > scr_w_reg) ? scr_w_reg : nw_reg;
        ch_sat  = (nh_reg > scr_h_reg) ? scr_h_reg : nh_reg;
        // drag clamp to 0 .. screen - size
        px = $signed({2'b00, mx_reg}) - $signed({2'b00, gdx_reg});
        py = $signed({2'b00, my_reg}) - $signed({2'b00, gdy_reg});
        hx = $signed({2'b00, scr_w_reg}) - $signed({2'b00, rect_rdata.width});
        hy = $signed({2'b00, scr_h_reg}) - $signed({2'b00, rect_rdata.height});
        cx = (px > hx) ? hx : px;
        cy = (py > hy) ? hy : py;
        nx = (cx < 0) ? '0 : cx[CW-1:0];
        ny = (cy < 0) ? '0 : cy[CW-1:0];
    end

    assign cmd.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        scr_w_next    = scr_w_reg;
        scr_h_next    = scr_h_reg;
        mode_next     = mode_reg;
        pr_next       = pr_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        nw_next       = nw_reg;
        nh_next       = nh_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        act_on_next   = act_on_reg;
        act_idx_next  = act_idx_reg;
        drag_on_next  = drag_on_reg;
        drag_idx_next = drag_idx_reg;
        gdx_next      = gdx_reg;
        gdy_next      = gdy_reg;
        prev_pr_next  = prev_pr_reg;
        casc_next     = casc_reg;
        touched_next  = touched_reg;
        created_next  = created_reg;
        rejected_next = rejected_reg;
        tslot_next    = tslot_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        ov_next       = ov_reg && !res.ready;
        o_act_v_next  = o_act_v_reg;
        o_act_s_next  = o_act_s_reg;
        o_drag_next   = o_drag_reg;
        o_touch_next  = o_touch_reg;
        o_win_s_next  = o_win_s_reg;
        o_x_next      = o_x_reg;
        o_y_next      = o_y_reg;
        o_cre_next    = o_cre_reg;
        o_rej_next    = o_rej_reg;
        ord_we     = 1'b0;
        ord_waddr  = '0;
        ord_wdata  = '0;
        ord_raddr  = '0;
        rect_we    = 1'b0;
        rect_waddr = '0;
        rect_wdata = '0;
        rect_raddr = '0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_next = cfg_data;
                REG_SCREEN_HEIGHT: scr_h_next = cfg_data;
                default:           scr_w_next = scr_w_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next     = cmd.mode;
                    pr_next       = cmd.pressed;
                    mx_next       = cmd.mouse_x;
                    my_next       = cmd.mouse_y;
                    nw_next       = cmd.new_width;
                    nh_next       = cmd.new_height;
                    touched_next  = 1'b0;
                    created_next  = 1'b0;
                    rejected_next = 1'b0;
                    tslot_next    = '0;
                    tx_next       = '0;
                    ty_next       = '0;
                    idx_next      = '0;
                    if (cmd.mode)
                    begin
                        state_next = S_CREATE;
                    end
                    else if (cmd.pressed && !prev_pr_reg)
                    begin
                        state_next = S_ORD_RD;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
            end
            // read the slot at this stack position, or finish a miss
            S_ORD_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    act_on_next  = 1'b0;
                    act_idx_next = '0;
                    if (corner)
                    begin
                        nw_next    = CW'(CORNER_W);
                        nh_next    = CW'(CORNER_H);
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
                else
                begin
                    ord_raddr  = idx_reg[SLOT_BITS-1:0];
                    state_next = S_RECT_RD;
                end
            end
            S_RECT_RD:
            begin
                slot_next  = ord_rdata;
                rect_raddr = ord_rdata;
                state_next = S_TEST;
            end
            // bounds test; a hit raises the window
            S_TEST:
            begin
                if (hit)
                begin
                    act_on_next  = 1'b1;
                    act_idx_next = slot_reg;
                    if (grab)
                    begin
                        drag_on_next  = 1'b1;
                        drag_idx_next = slot_reg;
                        gdx_next      = mx_reg - rect_rdata.left;
                        gdy_next      = my_reg - rect_rdata.top;
                    end
                    head_next  = slot_reg;
                    state_next = S_SH_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_BITS'(1);
                    state_next = S_ORD_RD;
                end
            end
            // new window at the cascade position, on top and active
            S_CREATE:
            begin
                if (full)
                begin
                    rejected_next = 1'b1;
                    state_next    = S_POST;
                end
                else
                begin
                    rect_we           = 1'b1;
                    rect_waddr        = count_reg[SLOT_BITS-1:0];
                    rect_wdata.left   = CW'(casc_reg);
                    rect_wdata.top    = CW'(casc_reg);
                    rect_wdata.width  = cw_sat;
                    rect_wdata.height = ch_sat;
                    touched_next  = 1'b1;
                    created_next  = 1'b1;
                    tslot_next    = count_reg[SLOT_BITS-1:0];
                    tx_next       = CW'(casc_reg);
                    ty_next       = CW'(casc_reg);
                    count_next    = count_reg + CNT_BITS'(1);
                    casc_next     = (casc_sum > (CASC_BITS+1)'(CASCADE_LIMIT)) ?
                                    CASC_BITS'(CASCADE_START) : casc_sum[CASC_BITS-1:0];
                    act_on_next   = 1'b1;
                    act_idx_next  = count_reg[SLOT_BITS-1:0];
                    head_next     = count_reg[SLOT_BITS-1:0];
                    idx_next      = count_reg;
                    state_next    = S_SH_RD;
                end
            end
            // shift the stack down by one from idx to the top
            S_SH_RD:
            begin
                if (idx_reg == '0)
                begin
                    ord_we     = 1'b1;
                    ord_waddr  = '0;
                    ord_wdata  = head_reg;
                    state_next = S_POST;
                end
                else
                begin
                    ord_raddr  = idx_dec[SLOT_BITS-1:0];
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                ord_we     = 1'b1;
                ord_waddr  = idx_reg[SLOT_BITS-1:0];
                ord_wdata  = ord_rdata;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end
            // drag follow-up and button release
            S_POST:
            begin
                if (mode_reg)
                begin
                    state_next = S_DONE;
                end
                else if (pr_reg && drag_on_reg)
                begin
                    rect_raddr = drag_idx_reg;
                    state_next = S_DRAG_WR;
                end
                else
                begin
                    if (!pr_reg)
                    begin
                        drag_on_next  = 1'b0;
                        drag_idx_next = '0;
                    end
                    prev_pr_next = pr_reg;
                    state_next   = S_DONE;
                end
            end
            S_DRAG_WR:
            begin
                rect_we           = 1'b1;
                rect_waddr        = drag_idx_reg;
                rect_wdata.left   = nx;
                rect_wdata.top    = ny;
                rect_wdata.width  = rect_rdata.width;
                rect_wdata.height = rect_rdata.height;
                touched_next = 1'b1;
                tslot_next   = drag_idx_reg;
                tx_next      = nx;
                ty_next      = ny;
                prev_pr_next = pr_reg;
                state_next   = S_DONE;
            end
            // hand the item to the output register
            S_DONE:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next      = 1'b1;
                    o_act_v_next = act_on_reg;
                    o_act_s_next = act_on_reg ? OUT_SLOT_BITS'(act_idx_reg) : '0;
                    o_drag_next  = drag_on_reg;
                    o_touch_next = touched_reg;
                    o_win_s_next = touched_reg ? OUT_SLOT_BITS'(tslot_reg) : '0;
                    o_x_next     = tx_reg;
                    o_y_next     = ty_reg;
                    o_cre_next   = created_reg;
                    o_rej_next   = rejected_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scr_w_reg    <= CW'(SCREEN_W_RST);
            scr_h_reg    <= CW'(SCREEN_H_RST);
            count_reg    <= '0;
            act_on_reg   <= 1'b0;
            act_idx_reg  <= '0;
            drag_on_reg  <= 1'b0;
            drag_idx_reg <= '0;
            gdx_reg      <= '0;
            gdy_reg      <= '0;
            prev_pr_reg  <= 1'b0;
            casc_reg     <= CASC_BITS'(CASCADE_START);
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scr_w_reg    <= scr_w_next;
            scr_h_reg    <= scr_h_next;
            count_reg    <= count_next;
            act_on_reg   <= act_on_next;
            act_idx_reg  <= act_idx_next;
            drag_on_reg  <= drag_on_next;
            drag_idx_reg <= drag_idx_next;
            gdx_reg      <= gdx_next;
            gdy_reg      <= gdy_next;
            prev_pr_reg  <= prev_pr_next;
            casc_reg     <= casc_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        pr_reg       <= pr_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        nw_reg       <= nw_next;
        nh_reg       <= nh_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        head_reg     <= head_next;
        touched_reg  <= touched_next;
        created_reg  <= created_next;
        rejected_reg <= rejected_next;
        tslot_reg    <= tslot_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        o_act_v_reg  <= o_act_v_next;
        o_act_s_reg  <= o_act_s_next;
        o_drag_reg   <= o_drag_next;
        o_touch_reg  <= o_touch_next;
        o_win_s_reg  <= o_win_s_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_cre_reg    <= o_cre_next;
        o_rej_reg    <= o_rej_next;
    end

    // result port
    assign res.valid          = ov_reg;
    assign res.active_valid   = o_act_v_reg;
    assign res.active_slot    = o_act_s_reg;
    assign res.dragging       = o_drag_reg;
    assign res.window_touched = o_touch_reg;
    assign res.window_slot    = o_win_s_reg;
    assign res.window_x       = o_x_reg;
    assign res.window_y       = o_y_reg;
    assign res.created        = o_cre_reg;
    assign res.rejected       = o_rej_reg;

    // checks
    `WSHD_ASSERT_ALWAYS(a_count_max, count_reg <= CNT_BITS'(MAX_WINDOWS))
    `WSHD_ASSERT_ALWAYS(a_active_exists, !act_on_reg || ({1'b0, act_idx_reg} < {1'b0, count_reg}))
    `WSHD_ASSERT_ALWAYS(a_drag_exists, !drag_on_reg || ({1'b0, drag_idx_reg} < {1'b0, count_reg}))
    `WSHD_ASSERT_NEXT(a_done_delivers, (state_reg == S_DONE) && !ov_reg, ov_reg && (state_reg == S_IDLE))
endmodule

>>> sv/wshd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module wshd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
